FILE: hdl/gap_buffer_editor_assert.svh
// Assertion macros for the gap buffer editor checker.
// Depends on nothing; included by the checker file only.
`ifndef GAP_BUFFER_EDITOR_ASSERT_SVH
`define GAP_BUFFER_EDITOR_ASSERT_SVH

// clocked check, quiet while reset is asserted
`define GBE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define GBE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/gbe_pkg.sv
// Shared types and codes for the gap buffer editor.
// No dependencies; imported by every module of the block.
package gbe_pkg;

  localparam int CHAR_W = 8;
  localparam int OFF_W  = 10;
  localparam int POS_W  = 9;
  localparam int ST_W   = 2;
  localparam int OP_W   = 2;
  localparam int IN_W   = 24;
  localparam int OUT_W  = 24;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_MOVE   = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic load;
    logic exec;
    logic rd;
    logic wr;
    logic out_load;
  } gbe_cmd_t;

  typedef struct packed {
    logic copy;
    logic last;
  } gbe_sts_t;

endpackage

FILE: hdl/gbe_dpath.sv
// Datapath: text store, cursor and gap end registers, copy counter, result word.
// Depends on gbe_pkg; driven by gbe_ctrl through gbe_cmd_t.
module gbe_dpath #(
  parameter int CAPACITY = 256
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [gbe_pkg::IN_W-1:0]  in_tdata,
  input  gbe_pkg::gbe_cmd_t       cmd,
  output gbe_pkg::gbe_sts_t       sts,
  output logic [gbe_pkg::OUT_W-1:0] out_tdata
);
  import gbe_pkg::*;

  localparam int IW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = ((IW > OFF_W) ? IW : OFF_W) + 1;
  localparam int LW = (IW > POS_W) ? IW : POS_W;
  localparam logic [IW-1:0] CAP_I = IW'(CAPACITY);

  logic [CHAR_W-1:0] mem [CAPACITY];

  logic [OP_W-1:0]   op_r;
  logic [CHAR_W-1:0] char_r;
  logic [OFF_W-1:0]  off_r;
  logic [IW-1:0]     cur_r, cur_nxt;
  logic [IW-1:0]     gap_r, gap_nxt;
  logic [ST_W-1:0]   status_r;
  logic [OFF_W-1:0]  count_r;
  logic [CHAR_W-1:0] rd_data_r;
  logic [OUT_W-1:0]  out_data_r;

  logic [OFF_W-1:0]  mag;
  logic [IW-1:0]     room, lim, cur_dec, gap_dec, len;
  logic              bad, full, empty, back, ins_ok, del_ok, wr_en;
  logic [ST_W-1:0]   status;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [CHAR_W-1:0] wr_data;
  logic [LW-1:0]     cur_ext, len_ext;

  always_comb begin
    back    = off_r[OFF_W-1];
    mag     = back ? OFF_W'(-off_r) : off_r;
    room    = CAP_I - gap_r;
    lim     = back ? cur_r : room;
    bad     = CW'(mag) > CW'(lim);
    full    = (cur_r == gap_r);
    empty   = (cur_r == '0);
    cur_dec = cur_r - IW'(1);
    gap_dec = gap_r - IW'(1);
    len     = cur_r + room;
    cur_ext = LW'(cur_r);
    len_ext = LW'(len);
  end

  always_comb begin
    unique case (op_r)
      OP_INSERT: status = full ? ST_FULL : ST_OK;
      OP_DELETE: status = empty ? ST_EMPTY : ST_OK;
      OP_MOVE:   status = ((mag != '0) && bad) ? ST_RANGE : ST_OK;
      default:   status = ST_OK;
    endcase
  end

  assign ins_ok   = cmd.exec && (op_r == OP_INSERT) && !full;
  assign del_ok   = cmd.exec && (op_r == OP_DELETE) && !empty;
  assign sts.copy = (op_r == OP_MOVE) && (mag != '0) && !bad;
  assign sts.last = (count_r == OFF_W'(1));

  assign rd_addr = back ? cur_dec[AW-1:0] : gap_r[AW-1:0];
  assign wr_en   = ins_ok || cmd.wr;
  assign wr_addr = (cmd.wr && back) ? gap_dec[AW-1:0] : cur_r[AW-1:0];
  assign wr_data = cmd.wr ? rd_data_r : char_r;

  always_comb begin
    cur_nxt = cur_r;
    gap_nxt = gap_r;
    priority if (ins_ok) begin
      cur_nxt = cur_r + IW'(1);
    end else if (del_ok) begin
      cur_nxt = cur_dec;
    end else if (cmd.wr && back) begin
      cur_nxt = cur_dec;
      gap_nxt = gap_dec;
    end else if (cmd.wr) begin
      cur_nxt = cur_r + IW'(1);
      gap_nxt = gap_r + IW'(1);
    end else begin
      cur_nxt = cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
      gap_r <= CAP_I;
    end else begin
      cur_r <= cur_nxt;
      gap_r <= gap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_tdata[OP_W-1:0];
      char_r <= in_tdata[OP_W+CHAR_W-1:OP_W];
      off_r  <= in_tdata[OP_W+CHAR_W+OFF_W-1:OP_W+CHAR_W];
    end
    if (cmd.exec) begin
      status_r <= status;
      count_r  <= mag;
    end else if (cmd.wr) begin
      count_r <= count_r - OFF_W'(1);
    end
    if (cmd.out_load) begin
      out_data_r <= {{(OUT_W - ST_W - 2 * POS_W){1'b0}},
                     len_ext[POS_W-1:0], cur_ext[POS_W-1:0], status_r};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_tdata = out_data_r;

endmodule

FILE: hdl/gbe_ctrl.sv
// Controller: sequences accept, execute, byte copy and result hand-off.
// Depends on gbe_pkg; commands gbe_dpath, owns the result valid flag.
module gbe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  gbe_pkg::gbe_sts_t sts,
  output gbe_pkg::gbe_cmd_t cmd
);
  import gbe_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RD,
    S_WR,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_tvalid_r;

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.copy ? S_RD : S_FIN;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_WR;
      end
      S_WR: begin
        cmd.wr    = 1'b1;
        state_nxt = sts.last ? S_FIN : S_RD;
      end
      S_FIN: begin
        if (!out_tvalid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;

endmodule

FILE: hdl/gap_buffer_editor.sv
// Top level of the gap buffer editor: stream ports, controller and datapath.
// Depends on gbe_pkg, gbe_ctrl and gbe_dpath.
//
//   channel  | dir | tdata bits, low first
//   in_      | in  | opcode[1:0], char_in[9:2], move_offset[19:10], zero[23:20]
//   out_     | out | status[1:0], cursor_pos[10:2], text_length[19:11], zero[23:20]
//
// Insert, delete, no-op and rejected ops go from accept through execute to the
// result step. A move that succeeds adds a copy loop; each byte crossing the gap
// takes a read step and then a write step on the text store.
// Reset clears cursor, gap end and the result valid flag; the store is not cleared.
// A result waits in the output register; the next word is accepted meanwhile
// and its result holds in the last step until the output register frees.
module gap_buffer_editor #(
  parameter int CAPACITY = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [gbe_pkg::IN_W-1:0]    in_tdata,   // opcode, char_in, move_offset
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [gbe_pkg::OUT_W-1:0]   out_tdata   // status, cursor_pos, text_length
);
  import gbe_pkg::*;

  gbe_cmd_t cmd;
  gbe_sts_t sts;

  gbe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  gbe_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata)
  );

endmodule

FILE: hdl/gbe_checker.sv
// Port-level checks for gap_buffer_editor, bound onto the top level.
// Depends on gbe_pkg and gap_buffer_editor_assert.svh.
`include "gap_buffer_editor_assert.svh"

module gbe_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [gbe_pkg::OUT_W-1:0] out_tdata
);
  import gbe_pkg::*;

  `GBE_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result word changed while stalled")
  `GBE_ASSERT_ALWAYS(a_rst_clear, !rst_n |=> !out_tvalid, "result valid after reset")
  `GBE_ASSERT(a_one_at_a_time, in_tvalid && in_tready |=> !in_tready, "input taken while an op is in flight")
  `GBE_ASSERT(a_empty_cursor, out_tvalid && (out_tdata[ST_W-1:0] == ST_EMPTY) |-> out_tdata[ST_W+POS_W-1:ST_W] == '0, "empty delete with nonzero cursor")

endmodule

bind gap_buffer_editor gbe_checker u_gbe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: verif/tb.sv
`timescale 1ns / 1ps
// Testbench for gap_buffer_editor: drives edit words, predicts each result, checks them in order.
// Depends on gbe_pkg and the gap_buffer_editor RTL; self-contained otherwise.

import gbe_pkg::*;

typedef struct {
  logic [ST_W-1:0]  status;
  logic [POS_W-1:0] cursor;
  logic [POS_W-1:0] length;
} edit_result_t;

class edit_scoreboard;
  int capacity;
  int cursor;
  int gap_end;
  edit_result_t pending_q[$];
  int errors;
  int checked;
  int status_seen[4];
  int peak_len;

  function new(input int cap);
    capacity = cap;
    cursor   = 0;
    gap_end  = cap;
  endfunction

  function void note(input logic [IN_W-1:0] w);
    logic [OP_W-1:0]         op;
    logic signed [OFF_W-1:0] off;
    int n;
    edit_result_t r;
    op = w[OP_W-1:0];
    off = w[OP_W+CHAR_W +: OFF_W];
    n = int'(off);
    r.status = ST_OK;
    case (op)
      OP_INSERT: begin
        if (cursor >= gap_end) r.status = ST_FULL;
        else cursor++;
      end
      OP_DELETE: begin
        if (cursor == 0) r.status = ST_EMPTY;
        else cursor--;
      end
      OP_MOVE: begin
        if (n > 0) begin
          if (n > capacity - gap_end) r.status = ST_RANGE;
          else begin
            cursor += n;
            gap_end += n;
          end
        end else if (n < 0) begin
          if (-n > cursor) r.status = ST_RANGE;
          else begin
            cursor += n;
            gap_end += n;
          end
        end
      end
      default: ;
    endcase
    r.cursor = POS_W'(cursor);
    r.length = POS_W'(cursor + capacity - gap_end);
    status_seen[r.status]++;
    if (cursor + capacity - gap_end > peak_len) peak_len = cursor + capacity - gap_end;
    pending_q.push_back(r);
  endfunction

  function void compare_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  function void check(input logic [OUT_W-1:0] w);
    edit_result_t r;
    if (pending_q.size() == 0) begin
      $display("%0t: result with nothing pending, expected none, actual %h", $time, w);
      errors++;
      return;
    end
    r = pending_q.pop_front();
    checked++;
    compare_field("status", r.status, w[ST_W-1:0]);
    compare_field("cursor_pos", r.cursor, w[ST_W +: POS_W]);
    compare_field("text_length", r.length, w[ST_W+POS_W +: POS_W]);
  endfunction
endclass

module tb;
  localparam int CAPACITY = 256;
  localparam int N_ITEMS  = 1850;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EDIT, MIX_WILD} mix_t;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;

  edit_scoreboard sb = new(CAPACITY);
  int idle_pct;
  int rx_hold;
  int sent;

  gap_buffer_editor #(.CAPACITY(CAPACITY)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check(out_tdata);
  end

  // stall the result side in bursts
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      out_tready <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      rx_hold = $urandom_range(17, 1) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic push_word(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                           input logic [OFF_W-1:0] off);
    in_tdata  <= {{(IN_W-OP_W-CHAR_W-OFF_W){1'b0}}, off, ch, op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    sent++;
  endtask

  task automatic hold_off(input int n);
    in_tvalid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (sb.pending_q.size() != 0);
  endtask

  function automatic int pick_len(input int lim);
    if ($urandom_range(19) == 0) return lim;
    return $urandom_range(lim < 16 ? lim : 16, 1);
  endfunction

  function automatic logic [OFF_W-1:0] pick_offset();
    int left;
    int right;
    int r;
    left  = sb.cursor;
    right = CAPACITY - sb.gap_end;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 20) begin
      if ($urandom_range(1)) return OFF_W'(right + $urandom_range(8, 1));
      return OFF_W'(-(left + int'($urandom_range(8, 1))));
    end
    if (left == 0 && right == 0) return '0;
    if (left == 0 || (right != 0 && $urandom_range(1))) return OFF_W'(pick_len(right));
    return OFF_W'(-pick_len(left));
  endfunction

  function automatic logic [OP_W-1:0] pick_op(input mix_t mix);
    int r;
    r = $urandom_range(99);
    case (mix)
      MIX_FILL:  return r < 80 ? OP_INSERT : r < 90 ? OP_MOVE : r < 96 ? OP_DELETE : OP_NOP;
      MIX_DRAIN: return r < 55 ? OP_DELETE : r < 80 ? OP_MOVE : r < 95 ? OP_INSERT : OP_NOP;
      MIX_EDIT:  return r < 40 ? OP_INSERT : r < 65 ? OP_DELETE : r < 95 ? OP_MOVE : OP_NOP;
      default:   return OP_W'($urandom_range(3));
    endcase
  endfunction

  initial begin
    #50_000_000;
    $display("%0t: timeout, %0d results still pending", $time, sb.pending_q.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    mix_t mix;
    int seg_left;
    int next_drain;
    logic [OP_W-1:0]  op;
    logic [OFF_W-1:0] off;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    idle_pct   = 0;
    rx_hold    = 0;
    sent       = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty buffer edges, byte extremes, offset extremes
    push_word(OP_DELETE, 8'h00, OFF_W'(0));
    push_word(OP_MOVE,   8'h00, OFF_W'(-1));
    push_word(OP_MOVE,   8'h00, OFF_W'(1));
    push_word(OP_MOVE,   8'hFF, OFF_W'(0));
    push_word(OP_NOP,    8'hFF, OFF_W'(-1));
    push_word(OP_INSERT, 8'h00, OFF_W'(0));
    push_word(OP_INSERT, 8'hFF, OFF_W'(-1));
    push_word(OP_INSERT, 8'hA5, OFF_W'(0));
    push_word(OP_MOVE,   8'h00, OFF_W'(-3));
    push_word(OP_MOVE,   8'h00, OFF_W'(4));
    push_word(OP_MOVE,   8'h00, OFF_W'(3));
    push_word(OP_MOVE,   8'h00, OFF_W'(-512));
    push_word(OP_MOVE,   8'h00, OFF_W'(511));
    push_word(OP_MOVE,   8'h00, OFF_W'(256));
    push_word(OP_MOVE,   8'h00, OFF_W'(-256));
    push_word(OP_DELETE, 8'h5A, OFF_W'(0));
    push_word(OP_MOVE,   8'h00, OFF_W'(-2));
    push_word(OP_DELETE, 8'h00, OFF_W'(0));
    push_word(OP_MOVE,   8'h00, OFF_W'(2));
    wait_drained();

    mix        = MIX_FILL;
    seg_left   = 320;
    idle_pct   = 10;
    next_drain = 500;
    while (sent < N_ITEMS) begin
      if (seg_left == 0) begin
        mix      = mix_t'($urandom_range(3));
        seg_left = $urandom_range(80, 30);
        case ($urandom_range(2))
          0:       idle_pct = 0;
          1:       idle_pct = 10;
          default: idle_pct = 35;
        endcase
      end
      if (N_ITEMS - sent <= 150) idle_pct = 0;
      if (sent >= next_drain) begin
        wait_drained();
        next_drain += 500;
      end
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) hold_off($urandom_range(17, 1));
      op = pick_op(mix);
      if (mix != MIX_WILD && op == OP_MOVE) off = pick_offset();
      else off = OFF_W'($urandom);
      push_word(op, CHAR_W'($urandom), off);
      seg_left--;
    end

    wait_drained();
    repeat (600) @(negedge clk);

    $display("Covered %0d edit words, %0d results checked, peak text length %0d of %0d.",
             sent, sb.checked, sb.peak_len, CAPACITY);
    $display("Status mix ok/full/empty/range: %0d/%0d/%0d/%0d, errors %0d.",
             sb.status_seen[ST_OK], sb.status_seen[ST_FULL], sb.status_seen[ST_EMPTY],
             sb.status_seen[ST_RANGE], sb.errors);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
